/* design/lpqt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpqt_pkg
// Shared types and constants of the live packet queue with latency trimming.
// ----------------------------------------------------------------------------
package lpqt_pkg;

  localparam int unsigned LPQT_CAPACITY = 32;
  localparam int unsigned MS_PER_S      = 1000;
  localparam int unsigned TS_W          = 63;
  localparam int unsigned HANDLE_W      = 16;
  localparam int unsigned BASE_W        = 41;   // time_base_num * 1000
  localparam int unsigned ACC_W         = 105;  // 64-bit span times BASE_W
  localparam int unsigned LIMIT_W       = 63;   // (max_span_ms + 1) * den
  localparam int unsigned CHUNK_W       = 16;

  // Operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_PUSHED      = 3'd0;
  localparam logic [2:0] KIND_FULL        = 3'd1;
  localparam logic [2:0] KIND_HALTED      = 3'd2;
  localparam logic [2:0] KIND_POPPED      = 3'd3;
  localparam logic [2:0] KIND_POP_EMPTY   = 3'd4;
  localparam logic [2:0] KIND_TRIMMED     = 3'd5;
  localparam logic [2:0] KIND_CLEARED     = 3'd6;

  // Register indexes
  localparam logic [2:0] REG_LIVE    = 3'd0;
  localparam logic [2:0] REG_CAP     = 3'd1;
  localparam logic [2:0] REG_NUM     = 3'd2;
  localparam logic [2:0] REG_DEN     = 3'd3;
  localparam logic [2:0] REG_MAXSPAN = 3'd4;
  localparam logic [2:0] REG_HALTED  = 3'd5;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TS_W-1:0]     pts;
    logic                pts_valid;
    logic [TS_W-1:0]     dts;
    logic                dts_valid;
    logic                key;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    entry_t      pkt;
    logic [5:0]  occupancy;
    logic [31:0] dropped_total;
  } result_t;

  typedef enum logic [1:0] {
    TAKE_POP   = 2'd0,
    TAKE_CLEAR = 2'd1,
    TAKE_ALL   = 2'd2,
    TAKE_NK    = 2'd3
  } take_e;

endpackage

/* design/live_packet_queue_trim_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// live_packet_queue_trim_top
// Packet descriptor FIFO with file-mode capacity limit and live-mode trimming.
// ----------------------------------------------------------------------------
// The descriptors live in one synchronous memory with two registered read
// ports (front and back entry); the block handles one transaction at a time.
// Each live-mode span check reads the memory and then runs a four-step 16-bit
// by 41-bit shift-and-add multiplier that rescales the span. Every result
// passes through a holding register so that the final result of a
// transaction can be marked.
module live_packet_queue_trim_top
  import lpqt_pkg::*;
#(
  parameter int unsigned CAPACITY = LPQT_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input transactions
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [TS_W-1:0]     pts_i,
  input  logic                pts_valid_i,
  input  logic [TS_W-1:0]     dts_i,
  input  logic                dts_valid_i,
  input  logic                key_i,
  // results
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          kind_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [TS_W-1:0]     out_pts_o,
  output logic                out_pts_valid_o,
  output logic [TS_W-1:0]     out_dts_o,
  output logic                out_dts_valid_o,
  output logic                out_key_o,
  output logic [5:0]          occupancy_o,
  output logic [31:0]         dropped_total_o,
  output logic                last_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_TAKE_RD = 9'b000000100,
    S_TAKE    = 9'b000001000,
    S_TRIM_RD = 9'b000010000,
    S_TRIM_TS = 9'b000100000,
    S_MUL     = 9'b001000000,
    S_CMP     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  // Configuration registers
  logic              live_q;
  logic [5:0]        cap_q;
  logic [30:0]       num_q, den_q, max_q;
  logic              halted_q;
  logic [BASE_W-1:0] base_q;
  logic [LIMIT_W-1:0] limit_q;

  logic wr_en;
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      REG_LIVE:    prdata = {31'd0, live_q};
      REG_CAP:     prdata = {26'd0, cap_q};
      REG_NUM:     prdata = {1'b0, num_q};
      REG_DEN:     prdata = {1'b0, den_q};
      REG_MAXSPAN: prdata = {1'b0, max_q};
      REG_HALTED:  prdata = {31'd0, halted_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= 1'b0;
      cap_q    <= 6'd32;
      num_q    <= 31'd1;
      den_q    <= 31'd1000;
      max_q    <= 31'd500;
      halted_q <= 1'b0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_LIVE:    live_q <= pwdata[0];
        REG_CAP:     cap_q  <= pwdata[5:0];
        REG_NUM:     num_q  <= pwdata[30:0];
        REG_DEN:     if (pwdata[30:0] != 31'd0) den_q <= pwdata[30:0];
        REG_MAXSPAN: if (pwdata[30:0] != 31'd0) max_q <= pwdata[30:0];
        REG_HALTED:  halted_q <= pwdata[0];
        default:     ;
      endcase
    end
  end

  // Rescale factors, settled long before any transaction follows a write.
  always_ff @(posedge clk_i) begin
    base_q  <= BASE_W'(num_q) * BASE_W'(MS_PER_S);
    limit_q <= (LIMIT_W'(max_q) + LIMIT_W'(1)) * LIMIT_W'(den_q);
  end

  // Descriptor memory
  entry_t entry_mem [CAPACITY];
  entry_t front_q, back_q;
  logic   mem_we;
  logic [AW-1:0] wr_addr, back_addr;

  // Queue state
  state_e          state_q, state_d;
  take_e           mode_q, mode_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [31:0]     drop_q, drop_d;
  logic [1:0]      op_q;
  entry_t          pkt_q;

  // Span rescale datapath
  logic [63:0]      span_q, span_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [1:0]       step_q, step_d;
  logic             fkey_q, fkey_d;
  logic [CHUNK_W+BASE_W-1:0] part_prod;

  // Result path
  result_t hold_q, hold_d, out_q, out_d;
  logic    hold_v_q, hold_v_d, out_v_q, out_v_d, last_q, last_d;

  assign wr_addr   = wrap_add(head_q, count_q);
  assign back_addr = wrap_add(head_q, count_q - CW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem[wr_addr] <= pkt_q;
    front_q <= entry_mem[head_q];
    back_q  <= entry_mem[back_addr];
  end

  logic          out_free, emit_req, emit_ok, fin_req;
  result_t       emit_res;
  logic [31:0]   drop_inc;
  logic          full;
  logic [63:0]   fts, bts;
  logic [ACC_W:0] cmp_sum;

  assign out_free   = !out_v_q || out_ready_i;
  assign emit_ok    = !hold_v_q || out_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign drop_inc   = (drop_q == 32'hFFFF_FFFF) ? drop_q : drop_q + 32'd1;
  assign full       = live_q ? (count_q >= CW'(CAPACITY))
                             : ((count_q >= CW'(CAPACITY)) ||
                                (CMPW'(count_q) >= CMPW'(cap_q)));
  // Biased timestamps compare as unsigned numbers.
  assign fts = front_q.pts_valid ? {~front_q.pts[TS_W-1], front_q.pts}
                                 : {~front_q.dts[TS_W-1], front_q.dts};
  assign bts = back_q.pts_valid  ? {~back_q.pts[TS_W-1], back_q.pts}
                                 : {~back_q.dts[TS_W-1], back_q.dts};
  assign cmp_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(den_q[30:1]);
  assign part_prod = span_q[63 -: CHUNK_W] * base_q;

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    head_d   = head_q;
    count_d  = count_q;
    drop_d   = drop_q;
    span_d   = span_q;
    acc_d    = acc_q;
    step_d   = step_q;
    fkey_d   = fkey_q;
    mem_we   = 1'b0;
    emit_req = 1'b0;
    fin_req  = 1'b0;
    emit_res = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (op_q)
          OP_PUSH: begin
            emit_req      = 1'b1;
            emit_res.pkt  = pkt_q;
            emit_res.dropped_total = drop_q;
            emit_res.occupancy     = 6'(count_q);
            if (halted_q) begin
              emit_res.kind = KIND_HALTED;
              if (emit_ok) state_d = S_DONE;
            end else if (full) begin
              emit_res.kind = KIND_FULL;
              if (emit_ok) state_d = S_DONE;
            end else begin
              emit_res.kind      = KIND_PUSHED;
              emit_res.occupancy = 6'(count_q + CW'(1));
              if (emit_ok) begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                state_d = live_q ? S_TRIM_RD : S_DONE;
              end
            end
          end
          OP_POP, OP_CLEAR: begin
            if (count_q == '0) begin
              emit_req = 1'b1;
              emit_res.kind = (op_q == OP_POP) ? KIND_POP_EMPTY : KIND_CLEARED;
              emit_res.dropped_total = drop_q;
              if (emit_ok) state_d = S_DONE;
            end else begin
              mode_d  = (op_q == OP_POP) ? TAKE_POP : TAKE_CLEAR;
              state_d = S_TAKE_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_TAKE_RD: state_d = S_TAKE;
      S_TAKE: begin
        if (mode_q == TAKE_NK && front_q.key) begin
          state_d = S_TRIM_RD;
        end else begin
          emit_req      = 1'b1;
          emit_res.pkt  = front_q;
          emit_res.occupancy = 6'(count_q - CW'(1));
          if (mode_q == TAKE_POP) emit_res.kind = KIND_POPPED;
          else if (mode_q == TAKE_CLEAR) emit_res.kind = KIND_CLEARED;
          else emit_res.kind = KIND_TRIMMED;
          emit_res.dropped_total = (emit_res.kind == KIND_TRIMMED) ? drop_inc : drop_q;
          if (emit_ok) begin
            head_d  = wrap_add(head_q, CW'(1));
            count_d = count_q - CW'(1);
            drop_d  = emit_res.dropped_total;
            state_d = (mode_q == TAKE_POP || count_q == CW'(1)) ? S_DONE : S_TAKE_RD;
          end
        end
      end
      S_TRIM_RD: begin
        state_d = (count_q >= CW'(2)) ? S_TRIM_TS : S_DONE;
      end
      S_TRIM_TS: begin
        fkey_d = front_q.key;
        span_d = bts - fts;
        acc_d  = '0;
        step_d = 2'd0;
        if (!(front_q.pts_valid || front_q.dts_valid) ||
            !(back_q.pts_valid || back_q.dts_valid) || bts <= fts)
          state_d = S_DONE;
        else
          state_d = S_MUL;
      end
      S_MUL: begin
        // Most significant chunk first: acc = acc * 2^16 + chunk * base.
        acc_d  = {acc_q[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(part_prod);
        span_d = {span_q[63-CHUNK_W:0], {CHUNK_W{1'b0}}};
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = S_CMP;
      end
      S_CMP: begin
        if (cmp_sum >= (ACC_W+1)'(limit_q)) begin
          mode_d  = fkey_q ? TAKE_ALL : TAKE_NK;
          state_d = S_TAKE_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        fin_req = 1'b1;
        if (!hold_v_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A new result pushes the held one out; the end of a transaction marks it last.
  always_comb begin
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    last_d   = last_q;
    out_v_d  = out_v_q && !out_ready_i;
    if (emit_req && emit_ok) begin
      if (hold_v_q) begin
        out_d   = hold_q;
        last_d  = 1'b0;
        out_v_d = 1'b1;
      end
      hold_d   = emit_res;
      hold_v_d = 1'b1;
    end else if (fin_req && hold_v_q && out_free) begin
      out_d    = hold_q;
      last_d   = 1'b1;
      out_v_d  = 1'b1;
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= TAKE_POP;
      head_q   <= '0;
      count_q  <= '0;
      drop_q   <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      step_q   <= step_d;
      if (wr_en && paddr[4:2] == REG_LIVE) begin
        head_q  <= '0;
        count_q <= '0;
        drop_q  <= '0;
      end else begin
        head_q  <= head_d;
        count_q <= count_d;
        drop_q  <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
    acc_q  <= acc_d;
    fkey_q <= fkey_d;
    hold_q <= hold_d;
    out_q  <= out_d;
    last_q <= last_d;
    if (in_valid_i && in_ready_o) begin
      op_q <= opcode_i;
      pkt_q <= '{handle: handle_i, pts: pts_i, pts_valid: pts_valid_i,
                 dts: dts_i, dts_valid: dts_valid_i, key: key_i};
    end
  end

  assign out_valid_o     = out_v_q;
  assign kind_o          = out_q.kind;
  assign out_handle_o    = out_q.pkt.handle;
  assign out_pts_o       = out_q.pkt.pts;
  assign out_pts_valid_o = out_q.pkt.pts_valid;
  assign out_dts_o       = out_q.pkt.dts;
  assign out_dts_valid_o = out_q.pkt.dts_valid;
  assign out_key_o       = out_q.pkt.key;
  assign occupancy_o     = out_q.occupancy;
  assign dropped_total_o = out_q.dropped_total;
  assign last_o          = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !hold_v_q)
    else $error("transaction accepted with a result still held");

  a_empty_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_POP_EMPTY) |-> (occupancy_o == 6'd0 && last_o))
    else $error("empty pop result inconsistent");

endmodule

/* dv/live_packet_queue_trim_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// live_packet_queue_trim_top_tb
// Self-checking testbench for the packet descriptor queue. A directed table is
// run first, then random phases in file and live mode with several time bases.
// Every result transaction is compared with the output of a behavioural queue
// model kept inside the testbench, or with a known result for typed table rows.
// ----------------------------------------------------------------------------
module live_packet_queue_trim_top_tb;
  import lpqt_pkg::*;

  localparam int unsigned CAP     = LPQT_CAPACITY;
  localparam logic [1:0]  OP_NONE = 2'd3;
  localparam logic [62:0] MIN_TS  = 63'h4000000000000000;
  localparam logic [62:0] MAX_TS  = 63'h3FFFFFFFFFFFFFFF;
  localparam int unsigned SETTLE  = 300;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] h;
    logic [62:0] pts;
    logic        pv;
    logic [62:0] dts;
    logic        dv;
    logic        key;
  } pkt_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] h;
    logic [62:0] pts;
    logic        pv;
    logic [62:0] dts;
    logic        dv;
    logic        key;
    logic [5:0]  occ;
    logic [31:0] drop;
    logic        last;
  } report_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    pkt_item_t   item;
    bit          typed;
    logic [2:0]  typed_kind;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_ready_o;
  logic [1:0] opcode_i;
  logic [15:0] handle_i;
  logic [62:0] pts_i, dts_i;
  logic pts_valid_i, dts_valid_i, key_i;
  logic out_valid_o, out_ready_i;
  logic [2:0] kind_o;
  logic [15:0] out_handle_o;
  logic [62:0] out_pts_o, out_dts_o;
  logic out_pts_valid_o, out_dts_valid_o, out_key_o, last_o;
  logic [5:0] occupancy_o;
  logic [31:0] dropped_total_o;

  live_packet_queue_trim_top DUT (.*);

  always #4 clk_i = ~clk_i;

  // Queue model state and its copy of the registers.
  logic [15:0] q_handle [CAP];
  logic [62:0] q_pts    [CAP];
  logic [62:0] q_dts    [CAP];
  logic [2:0]  q_flags  [CAP];   // {key, dts_valid, pts_valid}
  int unsigned q_head, q_count;
  logic [31:0] q_drops;
  logic        m_live, m_halted;
  logic [5:0]  m_cap;
  logic [30:0] m_num, m_den, m_max_span;

  report_t     pending_reports [$];
  int unsigned err_count;
  int unsigned tx_idle_pct, rx_stall_pct, rx_hold_cycles;
  logic signed [62:0] ts_cursor;

  function automatic int unsigned slot_at(int unsigned off);
    return (q_head + off) % CAP;
  endfunction

  function automatic void add_report(logic [2:0] kind, logic [15:0] h, logic [62:0] p,
                                     logic [2:0] fl, logic [62:0] d);
    pending_reports.push_back('{kind, h, p, fl[0], d, fl[1], fl[2], q_count[5:0],
                                q_drops, 1'b0});
  endfunction

  function automatic void take_front(logic [2:0] kind);
    int unsigned s;
    s = q_head;
    q_head = slot_at(1);
    q_count--;
    add_report(kind, q_handle[s], q_pts[s], q_flags[s], q_dts[s]);
  endfunction

  function automatic void drop_front();
    if (q_drops != 32'hFFFFFFFF) q_drops++;
    take_front(KIND_TRIMMED);
  endfunction

  function automatic bit stamp_of(int unsigned s, output logic signed [63:0] ts);
    if (q_flags[s][0]) begin
      ts = {q_pts[s][62], q_pts[s]};
      return 1;
    end
    if (q_flags[s][1]) begin
      ts = {q_dts[s][62], q_dts[s]};
      return 1;
    end
    ts = '0;
    return 0;
  endfunction

  // Rounded milliseconds of the span compared with the limit, in full width.
  function automatic bit span_too_long(logic [63:0] span);
    logic [127:0] scaled, limit;
    scaled = 128'(span) * (128'(m_num) * 128'd1000) + 128'(m_den >> 1);
    limit  = (128'(m_max_span) + 128'd1) * 128'(m_den);
    return scaled >= limit;
  endfunction

  function automatic void live_trim();
    logic signed [63:0] ft, bt;
    while (q_count >= 2) begin
      if (!stamp_of(q_head, ft) || !stamp_of(slot_at(q_count - 1), bt)) return;
      if (bt <= ft || !span_too_long(bt - ft)) return;
      if (q_flags[q_head][2]) begin
        while (q_count > 0) drop_front();
        return;
      end
      while (q_count > 0 && !q_flags[q_head][2]) drop_front();
    end
  endfunction

  function automatic void queue_model_step(pkt_item_t it);
    int unsigned lim, s, n_prior;
    logic [2:0] fl;
    n_prior = pending_reports.size();
    fl = {it.key, it.dv, it.pv};
    case (it.op)
      OP_PUSH: begin
        lim = m_live ? CAP : ((m_cap > CAP) ? CAP : m_cap);
        if (m_halted) add_report(KIND_HALTED, it.h, it.pts, fl, it.dts);
        else if (q_count >= lim) add_report(KIND_FULL, it.h, it.pts, fl, it.dts);
        else begin
          s = slot_at(q_count);
          q_handle[s] = it.h;
          q_pts[s] = it.pts;
          q_dts[s] = it.dts;
          q_flags[s] = fl;
          q_count++;
          add_report(KIND_PUSHED, it.h, it.pts, fl, it.dts);
          if (m_live) live_trim();
        end
      end
      OP_POP: begin
        if (q_count == 0) add_report(KIND_POP_EMPTY, '0, '0, '0, '0);
        else take_front(KIND_POPPED);
      end
      OP_CLEAR: begin
        if (q_count == 0) add_report(KIND_CLEARED, '0, '0, '0, '0);
        while (q_count > 0) take_front(KIND_CLEARED);
      end
      default: ;
    endcase
    if (pending_reports.size() > n_prior) pending_reports[$].last = 1'b1;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_LIVE: begin
        m_live = val[0];
        q_head = 0;
        q_count = 0;
        q_drops = '0;
      end
      REG_CAP:     m_cap = val[5:0];
      REG_NUM:     m_num = val[30:0];
      REG_DEN:     if (val[30:0] != 0) m_den = val[30:0];
      REG_MAXSPAN: if (val[30:0] != 0) m_max_span = val[30:0];
      REG_HALTED:  m_halted = val[0];
      default: ;
    endcase
  endfunction

  // Waits until every expected result has arrived and the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    model_config(idx, val);
    @(posedge clk_i);
  endtask

  // Offers one input transaction; returns at the edge that accepts it.
  task automatic send_item(pkt_item_t it, bit typed, logic [2:0] typed_kind);
    bit acc;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= it.op;
    handle_i <= it.h;
    pts_i <= it.pts;
    pts_valid_i <= it.pv;
    dts_i <= it.dts;
    dts_valid_i <= it.dv;
    key_i <= it.key;
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      if (acc) begin
        queue_model_step(it);
        // Typed rows replace the model's single result with the known one.
        if (typed) begin
          void'(pending_reports.pop_back());
          if (typed_kind == KIND_HALTED)
            pending_reports.push_back('{typed_kind, it.h, it.pts, it.pv, it.dts, it.dv,
                                        it.key, 6'd0, 32'd0, 1'b1});
          else
            pending_reports.push_back('{typed_kind, 16'd0, 63'd0, 1'b0, 63'd0, 1'b0,
                                        1'b0, 6'd0, 32'd0, 1'b1});
        end
      end
      @(posedge clk_i);
    end while (!acc);
  endtask

  function automatic pkt_item_t random_item(int unsigned step);
    pkt_item_t it;
    int unsigned r;
    r = $urandom_range(99);
    it.op  = (r < 62) ? OP_PUSH : (r < 84) ? OP_POP : (r < 95) ? OP_CLEAR : OP_NONE;
    it.h   = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(9) == 0) begin
      it.pts = 63'({$urandom, $urandom});
      it.dts = 63'({$urandom, $urandom});
      it.pv  = 1'($urandom_range(1));
      it.dv  = 1'($urandom_range(1));
    end else begin
      ts_cursor = ts_cursor + 63'($urandom_range(step));
      it.pts = ts_cursor;
      it.dts = ts_cursor - 63'($urandom_range(3));
      it.pv  = ($urandom_range(7) != 0);
      it.dv  = ($urandom_range(3) != 0);
    end
    it.key = ($urandom_range(5) == 0);
    return it;
  endfunction

  task automatic run_phase(logic live, logic [5:0] cap, logic [30:0] num, logic [30:0] den,
                           logic [30:0] max_span, logic halt, int unsigned idle_mode,
                           int unsigned step, int unsigned n_items);
    settle();
    reg_write(REG_LIVE, {31'd0, live});
    reg_write(REG_CAP, {26'd0, cap});
    reg_write(REG_NUM, {1'b0, num});
    reg_write(REG_DEN, {1'b0, den});
    reg_write(REG_MAXSPAN, {1'b0, max_span});
    reg_write(REG_HALTED, {31'd0, halt});
    case (idle_mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
      default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
    endcase
    ts_cursor = '0;
    for (int unsigned i = 0; i < n_items; i++) send_item(random_item(step), 1'b0, '0);
  endtask

  function automatic table_row_t cfg_row(logic [2:0] idx, logic [31:0] val);
    return '{1'b1, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic table_row_t pkt_row(logic [1:0] op, logic [15:0] h, logic [62:0] p,
                                         logic pv, logic [62:0] d, logic dv, logic k,
                                         bit typed = 0, logic [2:0] tk = '0);
    return '{1'b0, '0, '0, '{op, h, p, pv, d, dv, k}, typed, tk};
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Result checker; handshake values are stable at the falling edge.
  always @(negedge clk_i) begin
    report_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{kind_o, out_handle_o, out_pts_o, out_pts_valid_o, out_dts_o,
              out_dts_valid_o, out_key_o, occupancy_o, dropped_total_o, last_o};
      if (pending_reports.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    table_row_t rows [$];
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    opcode_i = OP_NONE;
    handle_i = '0;
    pts_i = '0;
    pts_valid_i = 1'b0;
    dts_i = '0;
    dts_valid_i = 1'b0;
    key_i = 1'b0;
    err_count = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_cycles = 0;
    ts_cursor = '0;
    q_head = 0;
    q_count = 0;
    q_drops = '0;
    m_live = 1'b0;
    m_halted = 1'b0;
    m_cap = 6'd32;
    m_num = 31'd1;
    m_den = 31'd1000;
    m_max_span = 31'd500;

    rows = '{
      pkt_row(OP_POP, 0, 0, 0, 0, 0, 0, 1, KIND_POP_EMPTY),
      pkt_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1, KIND_CLEARED),
      pkt_row(OP_PUSH, 16'h0000, MIN_TS, 1, MAX_TS, 1, 1),
      pkt_row(OP_PUSH, 16'hFFFF, MAX_TS, 0, MIN_TS, 1, 0),
      pkt_row(OP_POP, 0, 0, 0, 0, 0, 0),
      pkt_row(OP_CLEAR, 0, 0, 0, 0, 0, 0),
      cfg_row(REG_CAP, 32'd1),
      pkt_row(OP_PUSH, 16'd1, 63'd10, 1, 63'd9, 1, 0),
      pkt_row(OP_PUSH, 16'd2, 63'd20, 1, 63'd19, 1, 0),
      cfg_row(REG_CAP, 32'd0),
      pkt_row(OP_PUSH, 16'd3, 63'd30, 1, 63'd29, 1, 1),
      pkt_row(OP_CLEAR, 0, 0, 0, 0, 0, 0),
      cfg_row(REG_HALTED, 32'd1),
      pkt_row(OP_PUSH, 16'd4, 63'd40, 1, 63'd39, 0, 1, 1, KIND_HALTED),
      cfg_row(REG_HALTED, 32'd0),
      cfg_row(REG_LIVE, 32'd1),
      pkt_row(OP_PUSH, 16'd10, 63'd0, 1, 63'd0, 1, 1),
      pkt_row(OP_PUSH, 16'd11, 63'd100, 1, 63'd100, 1, 0),
      // Key-frame head with too long a span: the whole queue goes.
      pkt_row(OP_PUSH, 16'd12, 63'd700, 1, 63'd700, 1, 0),
      pkt_row(OP_PUSH, 16'd13, 63'd0, 0, 63'd0, 1, 0),
      pkt_row(OP_PUSH, 16'd14, 63'd10, 1, 63'd10, 1, 1),
      pkt_row(OP_PUSH, 16'd15, 63'd600, 1, 63'd600, 1, 0),
      // A packet with no timestamp stays at the front, so no span is checked.
      pkt_row(OP_PUSH, 16'd16, 63'd900, 0, 63'd900, 0, 0),
      pkt_row(OP_PUSH, 16'd17, 63'd20, 1, 63'd20, 1, 0),
      pkt_row(OP_NONE, 16'd18, 63'd5, 1, 63'd5, 1, 1),
      pkt_row(OP_POP, 0, 0, 0, 0, 0, 0)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        reg_write(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].item, rows[i].typed, rows[i].typed_kind);
      end
    end

    // File mode at full capacity with the receiver held off, so the block backs up.
    settle();
    rx_hold_cycles = 800;
    run_phase(1'b0, 6'd32, 31'd1, 31'd1000, 31'd500, 1'b0, 0, 5, 30);
    run_phase(1'b0, 6'd5, 31'd1, 31'd1000, 31'd500, 1'b0, 1, 5, 20);
    run_phase(1'b1, 6'd32, 31'd1, 31'd1000, 31'd500, 1'b0, 2, 150, 30);
    run_phase(1'b1, 6'd32, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, 3, 1 << 30, 25);
    settle();
    reg_write(REG_DEN, 32'd0);
    reg_write(REG_MAXSPAN, 32'd0);
    run_phase(1'b1, 6'd32, 31'd1, 31'd90000, 31'd1, 1'b0, 0, 60, 25);
    run_phase(1'b0, 6'd63, 31'd3, 31'd7, 31'd100, 1'b1, 1, 5, 10);
    run_phase(1'b1, 6'd32, 31'd1, 31'd1, 31'h7FFFFFFF, 1'b0, 3, 1 << 20, 30);

    settle();
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
